// ----- design/assert_macros.svh -----
// Assertion macros used by the sound generator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock outside reset.
`define PSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define PSG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- design/psg_pkg.sv -----
// Types, constants and the level table of the sound generator.
`default_nettype none
package psg_pkg;

  localparam int CountW = 7;
  localparam int PhaseW = 32;
  localparam int PeriodW = 28;
  localparam int AccW = 34;
  localparam int ProdW = 49;
  localparam int SumW = 51;
  localparam int LeftW = 18;

  localparam logic [15:0] STEP_RESET = 16'd12918;
  localparam logic [PhaseW-1:0] STEP_ONE = 32'h0001_0000;
  localparam logic [14:0] OUT_MAX = 15'h7fff;
  localparam logic [SumW-1:0] SUM_MAX = 51'h7fff_0000;
  localparam logic [16:0] FB_WHITE = 17'h14002;
  localparam logic [16:0] FB_PERIODIC = 17'h08000;
  localparam logic [16:0] SHIFT_PRESET = 17'h00f35;
  localparam logic [PeriodW-1:0] MIN_PERIOD = 28'h3fe;
  localparam logic [3:0] ATT_SILENT = 4'hf;
  localparam logic [2:0] REG_TONE0 = 3'd0;
  localparam logic [2:0] REG_TONE1 = 3'd2;
  localparam logic [2:0] REG_TONE2 = 3'd4;
  localparam logic [2:0] REG_NOISE = 3'd6;
  localparam logic [1:0] NOISE_LINKED = 2'd3;

  typedef struct packed {
    logic              load;
    logic              wr_regs;
    logic              wr_period;
    logic              ffwd;
    logic              t_init;
    logic              t_loop;
    logic              t_fin;
    logic              n_init;
    logic              n_step;
    logic              mul;
    logic              acc;
    logic              emit;
    logic              last;
    logic [1:0]        ch;
    logic [CountW-1:0] ff_n;
  } psg_cmd_t;

  typedef struct packed {
    logic tone_exit;
    logic noise_done;
    logic out_free;
  } psg_status_t;

  function automatic logic [13:0] volume_level(input logic [3:0] a);
    logic [13:0] v;
    case (a)
      4'd0:  v = 14'd10922;
      4'd1:  v = 14'd8877;
      4'd2:  v = 14'd7051;
      4'd3:  v = 14'd5601;
      4'd4:  v = 14'd4449;
      4'd5:  v = 14'd3534;
      4'd6:  v = 14'd2807;
      4'd7:  v = 14'd2229;
      4'd8:  v = 14'd1771;
      4'd9:  v = 14'd1407;
      4'd10: v = 14'd1117;
      4'd11: v = 14'd887;
      4'd12: v = 14'd705;
      4'd13: v = 14'd560;
      4'd14: v = 14'd444;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/psg_if.sv -----
// Request and sample channel interfaces.
`default_nettype none
interface psg_cmd_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] write_byte;
  logic [6:0] sample_count;
  modport source (output valid, op, write_byte, sample_count, input ready);
  modport sink (input valid, op, write_byte, sample_count, output ready);
endinterface

interface psg_smp_if;
  logic        valid;
  logic        ready;
  logic [14:0] sample;
  logic        last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface
`default_nettype wire

// ----- design/psg_ctrl.sv -----
// Sequencer for register writes and sample generation.
`default_nettype none
module psg_ctrl
  import psg_pkg::*;
#(
  parameter int MAX_BATCH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_op,
  input  wire logic [6:0]  req_count,
  output logic             req_ready,
  input  wire psg_status_t st,
  output psg_cmd_t         cmd
);

  typedef enum logic [3:0] {
    IDLE, WR1, WR2, FFWD, T_INIT, T_LOOP, T_FIN, N_INIT, N_STEP, MUL, ACC, EMIT
  } state_t;

  state_t state;
  logic [1:0] ch;
  logic [CountW-1:0] total;
  logic [CountW-1:0] done_cnt;
  logic [CountW-1:0] sat_count;
  logic accept;

  assign req_ready = (state == IDLE);
  assign accept = req_valid && req_ready;
  assign sat_count = (req_count > CountW'(MAX_BATCH)) ? CountW'(MAX_BATCH) : req_count;

  always_comb begin
    cmd = '0;
    cmd.ch = ch;
    cmd.ff_n = total;
    cmd.last = (done_cnt + CountW'(1) == total);
    cmd.load = accept;
    unique case (state)
      WR1:    cmd.wr_regs = 1'b1;
      WR2:    cmd.wr_period = 1'b1;
      FFWD:   cmd.ffwd = 1'b1;
      T_INIT: cmd.t_init = 1'b1;
      T_LOOP: cmd.t_loop = 1'b1;
      T_FIN:  cmd.t_fin = 1'b1;
      N_INIT: cmd.n_init = 1'b1;
      N_STEP: cmd.n_step = 1'b1;
      MUL:    cmd.mul = 1'b1;
      ACC:    cmd.acc = 1'b1;
      EMIT:   cmd.emit = st.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      ch <= '0;
      total <= '0;
      done_cnt <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            ch <= '0;
            done_cnt <= '0;
            total <= sat_count;
            if (!req_op) state <= WR1;
            else if (sat_count != '0) state <= FFWD;
          end
        end
        WR1: state <= WR2;
        WR2: state <= IDLE;
        FFWD: begin
          ch <= ch + 2'd1;
          if (ch == 2'd3) state <= T_INIT;
        end
        T_INIT: state <= T_LOOP;
        T_LOOP: if (st.tone_exit) state <= T_FIN;
        T_FIN: state <= MUL;
        N_INIT: state <= N_STEP;
        N_STEP: if (st.noise_done) state <= MUL;
        MUL: state <= ACC;
        ACC: begin
          if (ch == 2'd3) begin
            state <= EMIT;
          end else begin
            ch <= ch + 2'd1;
            state <= (ch == 2'd2) ? N_INIT : T_INIT;
          end
        end
        EMIT: begin
          if (st.out_free) begin
            ch <= '0;
            if (cmd.last) begin
              state <= IDLE;
            end else begin
              done_cnt <= done_cnt + CountW'(1);
              state <= T_INIT;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/psg_datapath.sv -----
// Channel registers, tone and noise step logic, mixer and output register.
`default_nettype none
module psg_datapath
  import psg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire psg_cmd_t    cmd,
  input  wire logic [7:0]  req_byte,
  input  wire logic [15:0] update_step,
  input  wire logic        out_ready,
  output psg_status_t      st,
  output logic             out_valid,
  output logic [14:0]      out_sample,
  output logic             out_last
);

  logic [9:0]               treg [8];
  logic [2:0]               latched;
  logic [PeriodW-1:0]       hp [4];
  logic signed [PhaseW-1:0] ph [4];
  logic [3:0]               att [4];
  logic [3:0]               lvl;
  logic [16:0]              shifter;
  logic                     white;
  logic [7:0]               byte_r;
  logic signed [AccW-1:0]   acc;
  logic signed [LeftW-1:0]  left;
  logic signed [ProdW-1:0]  prod;
  logic signed [SumW-1:0]   sum;

  logic signed [PhaseW-1:0] ph_c, p_c, ph_a, ph_b, ffv, ev, ph1, left_w, hp3_w;
  logic [2:0]               wr_r;
  logic [25:0]              tone_prod;
  logic [PeriodW-1:0]       tone_p, noise_p;
  logic [16:0]              sh_next;
  logic                     n_event, lvl_f;
  logic signed [LeftW-1:0]  left_next;

  assign ph_c = ph[cmd.ch];
  assign p_c = $signed({{(PhaseW-PeriodW){1'b0}}, hp[cmd.ch]});
  assign ph_a = ph_c + p_c;
  assign ph_b = ph_a + p_c;
  assign ffv = $signed({{(PhaseW-CountW-16){1'b0}}, cmd.ff_n, 16'b0});
  assign hp3_w = $signed({{(PhaseW-PeriodW){1'b0}}, hp[3]});

  assign left_w = PhaseW'(left);
  assign ev = (ph_c < left_w) ? ph_c : left_w;
  assign ph1 = ph_c - ev;
  assign n_event = (ph1 <= 0);
  assign sh_next = (shifter[0] ? (shifter ^ (white ? FB_WHITE : FB_PERIODIC)) : shifter) >> 1;
  assign lvl_f = n_event ? sh_next[0] : lvl[3];
  assign left_next = left - ev[LeftW-1:0];

  assign wr_r = latched;
  assign tone_prod = update_step * treg[wr_r];
  assign tone_p = (tone_prod == '0) ? MIN_PERIOD : PeriodW'(tone_prod);
  always_comb begin
    noise_p = PeriodW'({update_step, 5'b0}) << treg[REG_NOISE][1:0];
    if (noise_p == '0) noise_p = MIN_PERIOD;
  end

  assign st.tone_exit = (ph_c > 0) || (ph_a > 0);
  assign st.noise_done = (left_next <= 0);
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) treg[i] <= (i % 2 == 1) ? 10'h00f : 10'h000;
      for (int i = 0; i < 4; i++) begin
        hp[i] <= PeriodW'(STEP_RESET);
        ph[i] <= PhaseW'(STEP_RESET);
        att[i] <= ATT_SILENT;
      end
      latched <= '0;
      lvl <= {SHIFT_PRESET[0], 3'b000};
      shifter <= SHIFT_PRESET;
      white <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.wr_regs) begin
        if (byte_r[7]) begin
          latched <= byte_r[6:4];
          treg[byte_r[6:4]] <= {treg[byte_r[6:4]][9:4], byte_r[3:0]};
          if (byte_r[4]) att[byte_r[6:5]] <= byte_r[3:0];
          if (byte_r[6:4] == REG_NOISE) white <= byte_r[2];
        end else if (latched == REG_TONE0 || latched == REG_TONE1 || latched == REG_TONE2) begin
          treg[latched] <= {byte_r[5:0], treg[latched][3:0]};
        end
      end
      if (cmd.wr_period) begin
        if (wr_r == REG_TONE0 || wr_r == REG_TONE1 || wr_r == REG_TONE2) begin
          hp[wr_r[2:1]] <= tone_p;
          if (wr_r == REG_TONE2 && treg[REG_NOISE][1:0] == NOISE_LINKED)
            hp[3] <= tone_p << 1;
        end else if (wr_r == REG_NOISE && byte_r[7]) begin
          hp[3] <= (treg[REG_NOISE][1:0] == NOISE_LINKED) ? (hp[2] << 1) : noise_p;
        end
      end
      if (cmd.ffwd && att[cmd.ch] == ATT_SILENT && ph_c <= ffv) ph[cmd.ch] <= ph_c + ffv;
      if (cmd.t_init) ph[cmd.ch] <= ph_c - STEP_ONE;
      if (cmd.t_loop && ph_c <= 0) begin
        if (ph_a > 0) begin
          ph[cmd.ch] <= ph_a;
          lvl[cmd.ch] <= !lvl[cmd.ch];
        end else begin
          ph[cmd.ch] <= ph_b;
        end
      end
      if (cmd.n_step) begin
        ph[3] <= n_event ? (ph1 + hp3_w) : ph1;
        lvl[3] <= lvl_f;
        if (n_event) shifter <= sh_next;
      end
    end
  end

  // datapath registers with no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= req_byte;
      sum <= '0;
    end
    if (cmd.t_init) acc <= lvl[cmd.ch] ? AccW'(ph_c) : '0;
    if (cmd.t_loop && ph_c <= 0) begin
      if (ph_a <= 0 || !lvl[cmd.ch]) acc <= acc + AccW'(p_c);
    end
    if (cmd.t_fin && lvl[cmd.ch]) acc <= acc - AccW'(ph_c);
    if (cmd.n_init) begin
      acc <= '0;
      left <= LeftW'(STEP_ONE);
    end
    if (cmd.n_step) begin
      left <= left_next;
      acc <= acc + (lvl[3] ? AccW'(ph_c) : AccW'(0)) - (lvl_f ? AccW'(ph1) : AccW'(0));
    end
    if (cmd.mul) prod <= acc * $signed({1'b0, volume_level(att[cmd.ch])});
    if (cmd.acc) sum <= sum + SumW'(prod);
    if (cmd.emit) begin
      out_sample <= (sum < 0 || sum > $signed(SUM_MAX)) ? OUT_MAX : sum[30:16];
      out_last <= cmd.last;
      sum <= '0;
    end
  end

endmodule
`default_nettype wire

// ----- design/psg_tone_noise_generator.sv -----
// Top level: three tones and a noise channel, mixed to 15-bit samples.
// Usage:
//   cmd channel carries one request: op 0 writes write_byte to the tone
//   registers, op 1 asks for sample_count samples (saturated to MAX_BATCH,
//   zero gives nothing). smp channel returns one sample per handshake,
//   last_sample marks the final one of a request.
//   update_step sits at APB address 0; write it only while the block is idle.
// Sequence:
//   a register write passes through the WR1 and WR2 states before the
//   next request is taken. A generate request first fast-forwards the
//   silent channels in FFWD, then per sample runs each tone through
//   T_INIT, T_LOOP and T_FIN, the noise through N_INIT and N_STEP, each
//   channel then through MUL and ACC, and loads the output register in
//   EMIT; the T_LOOP and N_STEP loops set how long a sample takes.
// A new request is taken only after the last sample is loaded into the
// output register. If the receiver stalls, the next sample waits in the
// sequencer until the output register frees up.
// Reset: period registers 0, all channels silent, noise shifter preset, step 12918.
`default_nettype none
module psg_tone_noise_generator
  import psg_pkg::*;
#(
  parameter int MAX_BATCH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  psg_cmd_if.sink          cmd,
  psg_smp_if.source        smp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  `include "assert_macros.svh"

  logic [15:0] update_step;
  psg_cmd_t    ctl_cmd;
  psg_status_t ctl_st;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {16'b0, update_step} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_step <= STEP_RESET;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      update_step <= pwdata[15:0];
    end
  end

  psg_ctrl #(.MAX_BATCH(MAX_BATCH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (cmd.valid),
    .req_op    (cmd.op),
    .req_count (cmd.sample_count),
    .req_ready (cmd.ready),
    .st        (ctl_st),
    .cmd       (ctl_cmd)
  );

  psg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl_cmd),
    .req_byte    (cmd.write_byte),
    .update_step (update_step),
    .out_ready   (smp.ready),
    .st          (ctl_st),
    .out_valid   (smp.valid),
    .out_sample  (smp.sample),
    .out_last    (smp.last_sample)
  );

  `PSG_ASSERT(a_write_busy, cmd.valid && cmd.ready && !cmd.op |=> !cmd.ready, "write not held")
  `PSG_NEVER(a_idle_emit, cmd.ready && ctl_cmd.emit, "sample emitted while idle")
  `PSG_ASSERT(a_emit_free, ctl_cmd.emit |-> ctl_st.out_free, "output register overrun")

endmodule
`default_nettype wire

// ----- dv/psg_tb_pkg.sv -----
// Request codes and constants shared by the sound generator testbench modules.
package psg_tb_pkg;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_GEN   = 1'b1;
  localparam logic APB_ADDR_STEP = 1'b0;
  localparam int   BATCH_MAX = 64;
endpackage

// ----- dv/psg_checker.sv -----
// Sample predictor and scoreboard for the sound generator.
module psg_checker
  import psg_pkg::*;
  import psg_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  psg_cmd_if          cmd,
  psg_smp_if          smp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [14:0] level;
    logic        last;
  } sample_t;

  localparam longint TICK = 65536;
  localparam int ATTEN_DB [16] = '{10922, 8877, 7051, 5601, 4449, 3534, 2807, 2229,
                                   1771, 1407, 1117, 887, 705, 560, 444, 0};

  sample_t     samples_due[$];
  logic [15:0] step_val;
  logic [9:0]  tone_regs [8];
  logic [2:0]  latch_sel;
  longint      half_per [4];
  longint      phase [4];
  logic [3:0]  atten [4];
  logic        lvl [4];
  logic [16:0] lfsr;
  logic        white;

  function automatic void reset_state();
    step_val  = STEP_RESET;
    latch_sel = '0;
    for (int i = 0; i < 8; i += 2) begin
      tone_regs[i]     = '0;
      tone_regs[i + 1] = 10'h00f;
    end
    for (int i = 0; i < 4; i++) begin
      atten[i]    = ATT_SILENT;
      lvl[i]      = 1'b0;
      half_per[i] = STEP_RESET;
      phase[i]    = STEP_RESET;
    end
    lfsr   = SHIFT_PRESET;
    lvl[3] = lfsr[0];
    white  = 1'b0;
  endfunction

  function automatic void load_period(logic [2:0] r);
    longint p;
    p = longint'(step_val) * longint'(tone_regs[r]);
    if (p == 0) p = MIN_PERIOD;
    half_per[r[2:1]] = p;
    // tone 2 also drives the linked noise rate
    if (r == REG_TONE2 && tone_regs[REG_NOISE][1:0] == NOISE_LINKED)
      half_per[3] = 2 * half_per[2];
  endfunction

  function automatic void reg_write(logic [7:0] v);
    logic [2:0] r;
    longint     p;
    if (v[7]) begin
      r = v[6:4];
      latch_sel = r;
      tone_regs[r] = {tone_regs[r][9:4], v[3:0]};
      if (r == REG_TONE0 || r == REG_TONE1 || r == REG_TONE2) begin
        load_period(r);
      end else if (r[0]) begin
        atten[r[2:1]] = v[3:0];
      end else begin
        white = tone_regs[REG_NOISE][2];
        if (tone_regs[REG_NOISE][1:0] == NOISE_LINKED) begin
          half_per[3] = 2 * half_per[2];
        end else begin
          p = longint'(step_val) << (5 + tone_regs[REG_NOISE][1:0]);
          half_per[3] = (p == 0) ? longint'(MIN_PERIOD) : p;
        end
      end
    end else begin
      r = latch_sel;
      if (r == REG_TONE0 || r == REG_TONE1 || r == REG_TONE2) begin
        tone_regs[r] = {v[5:0], tone_regs[r][3:0]};
        load_period(r);
      end
    end
  endfunction

  function automatic longint tone_high(int i);
    longint acc;
    longint p;
    acc = 0;
    p = half_per[i];
    if (lvl[i]) acc += phase[i];
    phase[i] -= TICK;
    while (phase[i] <= 0) begin
      phase[i] += p;
      if (phase[i] > 0) begin
        lvl[i] = !lvl[i];
        if (lvl[i]) acc += p;
        break;
      end
      phase[i] += p;
      acc += p;
    end
    if (lvl[i]) acc -= phase[i];
    return acc;
  endfunction

  function automatic longint noise_high();
    longint      acc;
    longint      left;
    longint      ev;
    logic [16:0] fb;
    acc  = 0;
    left = TICK;
    fb   = white ? FB_WHITE : FB_PERIODIC;
    do begin
      ev = (phase[3] < left) ? phase[3] : left;
      if (lvl[3]) acc += phase[3];
      phase[3] -= ev;
      if (phase[3] <= 0) begin
        if (lfsr[0]) lfsr ^= fb;
        lfsr = lfsr >> 1;
        lvl[3] = lfsr[0];
        phase[3] += half_per[3];
        if (lvl[3]) acc += half_per[3];
      end
      if (lvl[3]) acc -= phase[3];
      left -= ev;
    end while (left > 0);
    return acc;
  endfunction

  function automatic void run_batch(logic [6:0] count);
    int      n;
    longint  ff;
    longint  hi [4];
    longint  mix;
    sample_t s;
    n = (count > BATCH_MAX) ? BATCH_MAX : int'(count);
    if (n == 0) return;
    ff = longint'(n) * TICK;
    // fast-forward silent channels over the whole batch
    for (int i = 0; i < 4; i++)
      if (ATTEN_DB[atten[i]] == 0 && phase[i] <= ff) phase[i] += ff;
    for (int k = 0; k < n; k++) begin
      mix = 0;
      for (int i = 0; i < 3; i++) hi[i] = tone_high(i);
      hi[3] = noise_high();
      for (int i = 0; i < 4; i++) mix += hi[i] * longint'(ATTEN_DB[atten[i]]);
      if (mix < 0 || mix > 64'h7fff_0000) mix = 64'h7fff_0000;
      s.level = 15'(mix / TICK);
      s.last  = (k + 1 == n);
      samples_due.push_back(s);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_state();
      samples_due.delete();
      errors <= 0;
    end else begin
      if (smp.valid && smp.ready) begin
        if (samples_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected sample %0d last %0b", smp.sample, smp.last_sample);
          errors <= errors + 1;
        end else begin
          sample_t s;
          s = samples_due.pop_front();
          if (smp.sample !== s.level || smp.last_sample !== s.last) begin
            if (errors < 10)
              $display("sample mismatch: expected %0d last %0b, got %0d last %0b",
                       s.level, s.last, smp.sample, smp.last_sample);
            errors <= errors + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == APB_ADDR_STEP)
        step_val = pwdata[15:0];
      if (cmd.valid && cmd.ready) begin
        if (cmd.op == OP_WRITE) reg_write(cmd.write_byte);
        else run_batch(cmd.sample_count);
      end
    end
    pending <= samples_due.size();
  end
endmodule

// ----- dv/tb.sv -----
// Top of the sound generator testbench: clock, reset, stimulus and verdict.
module tb;
  import psg_pkg::*;
  import psg_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic        paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  bit          steady;
  int          stall;

  psg_cmd_if cmd ();
  psg_smp_if smp ();

  psg_tone_noise_generator u_dut (
    .clk, .rst, .cmd(cmd.sink), .smp(smp.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  psg_checker u_chk (
    .clk, .rst, .cmd, .smp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.op = OP_WRITE;
    cmd.write_byte = '0;
    cmd.sample_count = '0;
    smp.ready = 1'b0;
    stall = 0;
  end

  // receiver: mostly ready, with short and occasional long stalls
  always @(posedge clk) begin
    if (stall > 0) begin
      smp.ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      smp.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0)
        stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (steady || r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic op, logic [7:0] wbyte, logic [6:0] count);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.op <= op;
    cmd.write_byte <= wbyte;
    cmd.sample_count <= count;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic settle_and_set_step(logic [15:0] value);
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= APB_ADDR_STEP;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [6:0] rand_count();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(65, 127));
    if ($urandom_range(0, 5) == 0) return 7'($urandom_range(0, 1));
    return 7'($urandom_range(1, 24));
  endfunction

  // generate requests, latch/data pairs on tone and noise registers, attenuation writes, some raw bytes
  task automatic random_traffic(int items);
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send(OP_GEN, 8'($urandom), rand_count());
        3, 4, 5: begin
          send(OP_WRITE, {1'b1, 2'($urandom), 1'b0, 4'($urandom)}, 7'($urandom));
          send(OP_WRITE, {1'b0, 7'($urandom)}, 7'($urandom));
        end
        6, 7: send(OP_WRITE, {1'b1, 3'($urandom_range(0, 3) * 2 + 1), 4'($urandom)},
                   7'($urandom));
        default: send(OP_WRITE, 8'($urandom), 7'($urandom));
      endcase
    end
  endtask

  initial begin
    steady = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: silent start, then every register, clamp, odd sizes
    send(OP_GEN, 8'h00, 7'd3);
    send(OP_WRITE, 8'h8f, 7'd0);
    send(OP_WRITE, 8'h3f, 7'd0);
    send(OP_WRITE, 8'h90, 7'd0);
    send(OP_WRITE, 8'ha1, 7'd0);
    send(OP_WRITE, 8'h00, 7'd0);
    send(OP_WRITE, 8'hb0, 7'd0);
    send(OP_WRITE, 8'hc0, 7'd0);
    send(OP_WRITE, 8'hd0, 7'd0);
    send(OP_WRITE, 8'he3, 7'd0);
    send(OP_WRITE, 8'hf0, 7'd0);
    send(OP_GEN, 8'hff, 7'd64);
    send(OP_WRITE, 8'h7f, 7'd0);
    send(OP_WRITE, 8'hc5, 7'd0);
    send(OP_GEN, 8'h00, 7'd127);
    send(OP_GEN, 8'h00, 7'd0);
    send(OP_WRITE, 8'he4, 7'd0);
    send(OP_WRITE, 8'h15, 7'd0);
    send(OP_WRITE, 8'hd8, 7'd0);
    send(OP_WRITE, 8'h2a, 7'd0);
    send(OP_GEN, 8'h00, 7'd1);
    send(OP_WRITE, 8'he7, 7'd0);
    send(OP_GEN, 8'h00, 7'd5);
    random_traffic(30);

    settle_and_set_step(16'hffff);
    random_traffic(25);

    // tiny step: keep periods as they are, touch only volumes
    settle_and_set_step(16'h0001);
    send(OP_WRITE, 8'h93, 7'd0);
    for (int i = 0; i < 15; i++) begin
      if ($urandom_range(0, 2) == 0)
        send(OP_GEN, 8'($urandom), 7'($urandom_range(1, 16)));
      else if ($urandom_range(0, 3) == 0)
        send(OP_WRITE, {1'b0, 7'($urandom)}, 7'($urandom));
      else
        send(OP_WRITE, {1'b1, 3'($urandom_range(0, 3) * 2 + 1), 4'($urandom)},
             7'($urandom));
    end

    settle_and_set_step(16'd300);
    steady = 1'b1;
    random_traffic(20);
    steady = 1'b0;
    random_traffic(10);

    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/psg_pkg.sv
design/psg_if.sv
design/psg_ctrl.sv
design/psg_datapath.sv
design/psg_tone_noise_generator.sv
dv/psg_tb_pkg.sv
dv/psg_checker.sv
dv/tb.sv
